FILE: hw/rtl/clsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsu_pkg
// Shared types and constants for the compacting list with search unit:
// operation and status codes, beat layouts and the result record.
// ----------------------------------------------------------------------------
package clsu_pkg;

   // Default geometry of the list storage.
   localparam int DEPTH_DEF       = 16;
   localparam int ENTRY_WIDTH_DEF = 32;

   // Field widths of the request and response beats.
   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 4;
   localparam int STATUS_W   = 3;
   localparam int FOUND_W    = 4;
   localparam int COUNT_W    = 5;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   // Operation codes.
   localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SHIFT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

   // Result record, status in the lowest bits.
   typedef struct packed {
      logic [COUNT_W-1:0]  entry_count;
      logic [FOUND_W-1:0]  found_index;
      logic [VALUE_W-1:0]  out_value;
      logic [STATUS_W-1:0] status;
   } rslt_type;

endpackage
`default_nettype wire

FILE: hw/rtl/clsu_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsu_mem
// Entry storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module clsu_mem #(
   parameter int DEPTH = clsu_pkg::DEPTH_DEF,
   parameter int WIDTH = clsu_pkg::ENTRY_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/clsu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsu_ctrl
// Operation sequencer: holds the entry count, walks the storage one read per
// cycle for pop, shift, search and remove, and writes entries back one slot
// lower to close the gap.
// ----------------------------------------------------------------------------
module clsu_ctrl #(
   parameter int DEPTH       = clsu_pkg::DEPTH_DEF,
   parameter int ENTRY_WIDTH = clsu_pkg::ENTRY_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [clsu_pkg::ACTION_W-1:0]      action,
   input  wire logic [clsu_pkg::VALUE_W-1:0]       entry_value,
   input  wire logic [clsu_pkg::POS_W-1:0]         position,
   input  wire logic                               slot_free,
   output logic                                    rslt_valid,
   output clsu_pkg::rslt_type                      rslt,
   output logic                                    wr_en,
   output logic      [$clog2(DEPTH)-1:0]           wr_addr,
   output logic      [ENTRY_WIDTH-1:0]             wr_data,
   output logic                                    rd_en,
   output logic      [$clog2(DEPTH)-1:0]           rd_addr,
   input  wire logic [ENTRY_WIDTH-1:0]             rd_data
);

   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int POS_W    = clsu_pkg::POS_W;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int VALUE_W  = clsu_pkg::VALUE_W;
   localparam int FOUND_W  = clsu_pkg::FOUND_W;
   localparam int COUNT_W  = clsu_pkg::COUNT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                         state_ff,   state_in;
   logic [clsu_pkg::ACTION_W-1:0]     act_ff,     act_in;
   logic [ENTRY_WIDTH-1:0]            val_ff,     val_in;
   logic [POS_W-1:0]                  pos_ff,     pos_in;
   logic [CNT_W-1:0]                  count_ff,   count_in;
   logic [CNT_W-1:0]                  rd_ptr_ff,  rd_ptr_in;
   logic                              rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]                  rd_addr_ff, rd_addr_in;
   logic [clsu_pkg::STATUS_W-1:0]     status_ff,  status_in;
   logic [ENTRY_WIDTH-1:0]            taken_ff,   taken_in;
   logic [IDX_W-1:0]                  found_ff,   found_in;

   logic [IDX_W-1:0] slot;
   logic             more;

   // Shift closes the gap at the head, remove at the given position.
   assign slot = (act_ff == clsu_pkg::ACT_SHIFT) ? '0 : IDX_W'(pos_ff);
   assign more = (rd_ptr_ff < count_ff);

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      val_in      = val_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_valid_in = 1'b0;
      rd_addr_in  = rd_addr_ff;
      status_in   = status_ff;
      taken_in    = taken_ff;
      found_in    = found_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = val_ff;
      rd_en       = 1'b0;
      rd_addr     = rd_ptr_ff[IDX_W-1:0];
      rslt_valid  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in    = action;
               val_in    = ENTRY_WIDTH'(entry_value);
               pos_in    = position;
               status_in = clsu_pkg::ST_OK;
               taken_in  = '0;
               found_in  = '0;
               state_in  = S_START;
            end
         end
         S_START: begin
            state_in = S_DONE;
            case (act_ff)
               clsu_pkg::ACT_PUSH: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     status_in = clsu_pkg::ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               clsu_pkg::ACT_POP: begin
                  if (count_ff == '0) begin
                     status_in = clsu_pkg::ST_EMPTY;
                  end else begin
                     rd_ptr_in = count_ff - CNT_W'(1);
                     state_in  = S_SCAN;
                  end
               end
               clsu_pkg::ACT_SHIFT: begin
                  if (count_ff == '0) begin
                     status_in = clsu_pkg::ST_EMPTY;
                  end else begin
                     rd_ptr_in = '0;
                     state_in  = S_SCAN;
                  end
               end
               clsu_pkg::ACT_SEARCH: begin
                  status_in = clsu_pkg::ST_NOT_FOUND;
                  rd_ptr_in = '0;
                  state_in  = S_SCAN;
               end
               clsu_pkg::ACT_REMOVE: begin
                  if (CMP_W'(pos_ff) >= CMP_W'(count_ff)) begin
                     status_in = clsu_pkg::ST_BAD_INDEX;
                  end else begin
                     rd_ptr_in = CNT_W'(pos_ff);
                     state_in  = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            // One read issued per cycle; the write back goes two slots below
            // the address being read, so no read ever meets a pending write.
            if (more) begin
               rd_en       = 1'b1;
               rd_ptr_in   = rd_ptr_ff + CNT_W'(1);
               rd_valid_in = 1'b1;
               rd_addr_in  = rd_ptr_ff[IDX_W-1:0];
            end
            if (rd_valid_ff) begin
               case (act_ff)
                  clsu_pkg::ACT_POP: begin
                     taken_in = rd_data;
                  end
                  clsu_pkg::ACT_SEARCH: begin
                     if (rd_data == val_ff) begin
                        status_in   = clsu_pkg::ST_OK;
                        found_in    = rd_addr_ff;
                        rd_valid_in = 1'b0;
                        state_in    = S_DONE;
                     end
                  end
                  default: begin
                     if (rd_addr_ff == slot) begin
                        if (act_ff == clsu_pkg::ACT_SHIFT) begin
                           taken_in = rd_data;
                        end
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = rd_addr_ff - IDX_W'(1);
                        wr_data = rd_data;
                     end
                  end
               endcase
            end else if (!more) begin
               if (act_ff != clsu_pkg::ACT_SEARCH) begin
                  count_in = count_ff - CNT_W'(1);
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rslt_valid = slot_free;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
      act_ff     <= act_in;
      val_ff     <= val_in;
      pos_ff     <= pos_in;
      rd_ptr_ff  <= rd_ptr_in;
      rd_addr_ff <= rd_addr_in;
      status_ff  <= status_in;
      taken_ff   <= taken_in;
      found_ff   <= found_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rslt.status       = status_ff;
   assign rslt.out_value    = VALUE_W'(taken_ff);
   assign rslt.found_index  = FOUND_W'(found_ff);
   assign rslt.entry_count  = COUNT_W'(count_ff);

`ifndef SYNTH
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      wr_en && rd_en |-> wr_addr != rd_addr)
      else $error("write and read of the same entry in one cycle");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff == S_START |-> count_ff < CNT_W'(DEPTH))
      else $error("push written while the list is full");

   a_count_moves_at_end: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(state_ff) == S_START || $past(state_ff) == S_SCAN)
      else $error("entry count changed outside an operation");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/compacting_list_with_search_unit.sv
`default_nettype none
// Pop reads only the last entry; shift and remove walk the entries from the
// freed slot up, and search walks from the head and stops at the first match.
// One item at a time: a new request is taken only after the response of the
// last one is loaded, and the walk over the entry memory reads one entry per
// cycle. Reset empties the list; memory contents are not cleared and need no
// clearing pass.
// ----------------------------------------------------------------------------
// compacting_list_with_search_unit
// Bounded, densely packed list with push, pop, shift, search and remove,
// one response beat per request beat, with a registered response slot.
// ----------------------------------------------------------------------------
module compacting_list_with_search_unit #(
   parameter int DEPTH       = clsu_pkg::DEPTH_DEF,
   parameter int ENTRY_WIDTH = clsu_pkg::ENTRY_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // action [2:0], entry_value [34:3], position [38:35], zero [39]
   input  wire logic [clsu_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status [2:0], out_value [34:3], found_index [38:35],
   // entry_count [43:39], zero [47:44]
   output logic      [clsu_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int A_W    = clsu_pkg::ACTION_W;
   localparam int V_W    = clsu_pkg::VALUE_W;
   localparam int P_W    = clsu_pkg::POS_W;
   localparam int RSLT_W = $bits(clsu_pkg::rslt_type);
   localparam int PAD_W  = clsu_pkg::RSP_TDATA_W - RSLT_W;

   logic                   slot_free;
   logic                   rslt_valid;
   clsu_pkg::rslt_type     rslt;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENTRY_WIDTH-1:0] wr_data;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [ENTRY_WIDTH-1:0] rd_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   clsu_pkg::rslt_type     rsp_data_ff,  rsp_data_in;

   clsu_ctrl #(
      .DEPTH       (DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .action      (req_tdata[A_W-1:0]),
      .entry_value (req_tdata[A_W+V_W-1:A_W]),
      .position    (req_tdata[A_W+V_W+P_W-1:A_W+V_W]),
      .slot_free   (slot_free),
      .rslt_valid  (rslt_valid),
      .rslt        (rslt),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   clsu_mem #(
      .DEPTH (DEPTH),
      .WIDTH (ENTRY_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The response slot may be refilled in the cycle its beat is taken.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rslt_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rslt;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_data_ff};

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rslt_valid |-> slot_free)
      else $error("result loaded over a response beat not yet taken");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      rslt_valid |=> rsp_tvalid && rsp_tdata[RSLT_W-1:0] == $past(rslt))
      else $error("loaded result does not appear on the response port");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while an item is in progress");
`endif

endmodule
`default_nettype wire
